// ----- hw/rtl/psp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psp_pkg: shared types and constants for the PID servo position loop
// Field widths, register indexes, loop phases and the queue item format.
// ----------------------------------------------------------------------------
package psp_pkg;

    // Field and datapath widths
    localparam int POS_W     = 32;
    localparam int ERR_W     = POS_W + 1;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int SUM_W     = 48;
    localparam int DRIVE_W   = 17;
    localparam int GAIN_W    = 32;
    localparam int LIMIT_W   = 16;
    localparam int BAND_W    = 16;
    localparam int SETTLE_W  = 8;
    localparam int TICK_W    = 12;
    localparam int STATUS_W  = 2;
    localparam int MAG_W     = SUM_W;
    localparam int DIGIT_W   = MAG_W / 2;
    localparam int PART_W    = GAIN_W + DIGIT_W;
    localparam int PROD_W    = GAIN_W + MAG_W;
    localparam int SAT_W     = 61;
    localparam int TERM_W    = SAT_W + 1;
    localparam int ACC_W     = 64;
    localparam int FRAC_W    = 24;
    localparam int QUO_W     = ACC_W - FRAC_W;

    // Product clamp (2^60) and integrator limits
    localparam logic [PROD_W-1:0] TERM_LIM = PROD_W'(1) << (SAT_W - 1);
    localparam logic [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};

    // Multiply lanes
    localparam int NUM_LANES  = 3;
    localparam int LANE_PROP  = 0;
    localparam int LANE_INTEG = 1;
    localparam int LANE_DERIV = 2;

    // Item queue
    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP     = 3'd0,
        CFG_GAIN_INTEG    = 3'd1,
        CFG_GAIN_DERIV    = 3'd2,
        CFG_OUTPUT_LIMIT  = 3'd3,
        CFG_SETTLE_BAND   = 3'd4,
        CFG_SETTLE_TICKS  = 3'd5,
        CFG_TIMEOUT_TICKS = 3'd6
    } cfg_index_t;

    localparam logic [GAIN_W-1:0]   RST_GAIN_PROP     = 32'd16777216;
    localparam logic [GAIN_W-1:0]   RST_GAIN_INTEG    = 32'd126;
    localparam logic [GAIN_W-1:0]   RST_GAIN_DERIV    = 32'd838860800;
    localparam logic [LIMIT_W-1:0]  RST_OUTPUT_LIMIT  = 16'd51200;
    localparam logic [BAND_W-1:0]   RST_SETTLE_BAND   = 16'd256;
    localparam logic [SETTLE_W-1:0] RST_SETTLE_TICKS  = 8'd100;
    localparam logic [TICK_W-1:0]   RST_TIMEOUT_TICKS = 12'd750;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain_prop;
        logic [GAIN_W-1:0]   gain_integ;
        logic [GAIN_W-1:0]   gain_deriv;
        logic [LIMIT_W-1:0]  output_limit;
        logic [BAND_W-1:0]   settle_band;
        logic [SETTLE_W-1:0] settle_ticks;
        logic [TICK_W-1:0]   timeout_ticks;
    } cfg_t;

    // Loop phase, same codes as the status field
    typedef enum logic [STATUS_W-1:0] {
        PH_RUN     = 2'd0,
        PH_SETTLED = 2'd1,
        PH_TIMEOUT = 2'd2,
        PH_IDLE    = 2'd3
    } phase_t;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_START = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic signed [POS_W-1:0] target;
        logic signed [POS_W-1:0] position;
    } item_t;

    typedef enum logic [3:0] {
        BK_FETCH,
        BK_CHECK,
        BK_ACCUM,
        BK_MAG,
        BK_MUL_LO,
        BK_MUL_HI,
        BK_COMBINE,
        BK_SAT,
        BK_SUM,
        BK_FINISH,
        BK_EMIT
    } back_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/pid_servo_position_loop_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pid_servo_position_loop_top: PID servo position loop
// Conditional-integration PID controller: one drive and status per tick.
//
//   channel   direction  handshake            payload
//   cfg       in         cfg_we               cfg_index, cfg_data
//   in        in         in_valid / in_ready  start_req, target, position
//   out       out        out_valid/out_ready  drive, status
//
// A running tick steps the back sequencer through fetch, check, integrator,
// magnitude, two multiply passes, combine, saturate, sum and clamp; a tick
// while idle, settled or timed out passes only fetch and check. The loop
// through the clamped drive and the integrator keeps ticks from overlapping.
// Input register plus a 2-entry queue accept transactions while the back
// part works or the output register waits. Reset restores the register
// defaults and the idle phase.
// ----------------------------------------------------------------------------
module pid_servo_position_loop_top
    import psp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      start_req,
    input  wire logic signed [POS_W-1:0]   target,
    input  wire logic signed [POS_W-1:0]   position,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [DRIVE_W-1:0]      drive,
    output logic        [STATUS_W-1:0]     status
);

    cfg_t  cfg;
    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  head_valid;
    logic  head_ready;
    item_t head_item;

    psp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_req  (start_req),
        .target     (target),
        .position   (position),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    psp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_item   (head_item)
    );

    psp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head_item  (head_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive      (drive),
        .status     (status)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/psp_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psp_cfg: configuration register file
// Holds gains, drive limit, settle band and tick limits; plain write port.
// ----------------------------------------------------------------------------
module psp_cfg
    import psp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAIN_PROP:     cfg_next.gain_prop     = cfg_data[GAIN_W-1:0];
                CFG_GAIN_INTEG:    cfg_next.gain_integ    = cfg_data[GAIN_W-1:0];
                CFG_GAIN_DERIV:    cfg_next.gain_deriv    = cfg_data[GAIN_W-1:0];
                CFG_OUTPUT_LIMIT:  cfg_next.output_limit  = cfg_data[LIMIT_W-1:0];
                CFG_SETTLE_BAND:   cfg_next.settle_band   = cfg_data[BAND_W-1:0];
                CFG_SETTLE_TICKS:  cfg_next.settle_ticks  = cfg_data[SETTLE_W-1:0];
                CFG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_data[TICK_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop     <= RST_GAIN_PROP;
            cfg_reg.gain_integ    <= RST_GAIN_INTEG;
            cfg_reg.gain_deriv    <= RST_GAIN_DERIV;
            cfg_reg.output_limit  <= RST_OUTPUT_LIMIT;
            cfg_reg.settle_band   <= RST_SETTLE_BAND;
            cfg_reg.settle_ticks  <= RST_SETTLE_TICKS;
            cfg_reg.timeout_ticks <= RST_TIMEOUT_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/psp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psp_front: input stage
// Registers each input transaction, tags it as start or tick, and pushes it
// into the item queue.
// ----------------------------------------------------------------------------
module psp_front
    import psp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    start_req,
    input  wire logic signed [POS_W-1:0] target,
    input  wire logic signed [POS_W-1:0] position,
    output logic                         push_valid,
    input  wire logic                    push_ready,
    output item_t                        push_item
);

    logic  hold_valid_reg;
    logic  hold_valid_next;
    item_t hold_item_reg;
    item_t hold_item_next;

    assign in_ready = !hold_valid_reg || push_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg && !push_ready;
        hold_item_next  = hold_item_reg;
        if (in_valid && in_ready)
        begin
            hold_valid_next         = 1'b1;
            hold_item_next.kind     = start_req ? KIND_START : KIND_TICK;
            // a tick carries no target
            hold_item_next.target   = start_req ? target : '0;
            hold_item_next.position = position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_item_reg <= hold_item_next;
    end

    assign push_valid = hold_valid_reg;
    assign push_item  = hold_item_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/psp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psp_queue: item queue between front and back
// Small first-in first-out buffer of tagged items.
// ----------------------------------------------------------------------------
module psp_queue
    import psp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire item_t push_item,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output item_t      pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/psp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psp_back: control loop sequencer
// Runs one tick at a time: phase and timeout check, error and integrator,
// three gain lanes with split multiplies, saturation, sum, clamp and settle
// logic. Holds the finished result in an output register.
// ----------------------------------------------------------------------------
module psp_back
    import psp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cfg_t                      cfg,
    input  wire logic                      head_valid,
    output logic                           head_ready,
    input  wire item_t                     head_item,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [DRIVE_W-1:0]      drive,
    output logic        [STATUS_W-1:0]     status
);

    // Sequencer and loop state
    back_state_t               state_reg, state_next;
    logic signed [POS_W-1:0]   target_reg, target_next;
    logic signed [ERR_W-1:0]   prev_error_reg, prev_error_next;
    logic signed [SUM_W-1:0]   error_sum_reg, error_sum_next;
    logic signed [DRIVE_W-1:0] last_drive_reg, last_drive_next;
    logic [SETTLE_W-1:0]       stable_count_reg, stable_count_next;
    logic [TICK_W-1:0]         tick_count_reg, tick_count_next;
    phase_t                    phase_reg, phase_next;

    // Per-tick working registers
    logic signed [POS_W-1:0]   pos_reg, pos_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic                      in_band_reg, in_band_next;
    logic [MAG_W-1:0]          mag_reg   [NUM_LANES];
    logic [MAG_W-1:0]          mag_next  [NUM_LANES];
    logic                      neg_reg   [NUM_LANES];
    logic                      neg_next  [NUM_LANES];
    logic [PART_W-1:0]         plo_reg   [NUM_LANES];
    logic [PART_W-1:0]         plo_next  [NUM_LANES];
    logic [PART_W-1:0]         phi_reg   [NUM_LANES];
    logic [PART_W-1:0]         phi_next  [NUM_LANES];
    logic [PROD_W-1:0]         term_reg  [NUM_LANES];
    logic [PROD_W-1:0]         term_next [NUM_LANES];
    logic signed [TERM_W-1:0]  sterm_reg [NUM_LANES];
    logic signed [TERM_W-1:0]  sterm_next[NUM_LANES];
    logic signed [ACC_W-1:0]   sum_reg, sum_next;
    logic signed [DRIVE_W-1:0] res_drive_reg, res_drive_next;
    logic [STATUS_W-1:0]       res_status_reg, res_status_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;
    logic [STATUS_W-1:0]       status_reg, status_next;

    // Datapath helpers
    logic signed [DRIVE_W:0]   lim_s;
    logic signed [DRIVE_W:0]   neg_lim_s;
    logic signed [DRIVE_W:0]   last_s;
    logic                      integrate;
    logic [SUM_W:0]            sum_wide;
    logic [SUM_W-1:0]          sum_sat;
    logic [ERR_W-1:0]          err_mag;
    logic signed [DIFF_W-1:0]  diff_calc;
    logic [GAIN_W-1:0]         gain_lane [NUM_LANES];
    logic [MAG_W-1:0]          lane_val  [NUM_LANES];
    logic [MAG_W-1:0]          lane_mag  [NUM_LANES];
    logic [DIGIT_W-1:0]        digit_sel [NUM_LANES];
    logic [PART_W-1:0]         prod      [NUM_LANES];
    logic [PROD_W-1:0]         term_calc [NUM_LANES];
    logic [SAT_W-1:0]          term_sat  [NUM_LANES];
    logic signed [TERM_W-1:0]  sterm_calc[NUM_LANES];
    logic signed [ACC_W-1:0]   total_neg;
    logic signed [QUO_W-1:0]   quo;
    logic signed [QUO_W-1:0]   lim_q;
    logic signed [QUO_W-1:0]   neg_lim_q;
    logic signed [QUO_W-1:0]   quo_clamped;
    logic                      out_free;
    logic                      done_valid;
    logic signed [DRIVE_W-1:0] done_drive;
    logic [STATUS_W-1:0]       done_status;

    // Integrate only while the previous drive sits strictly inside the limit
    assign lim_s     = {2'b00, cfg.output_limit};
    assign neg_lim_s = -lim_s;
    assign last_s    = {last_drive_reg[DRIVE_W-1], last_drive_reg};
    assign integrate = (last_s < lim_s) && (last_s > neg_lim_s);

    assign sum_wide = {error_sum_reg[SUM_W-1], error_sum_reg}
                    + {{(SUM_W-ERR_W+1){err_reg[ERR_W-1]}}, err_reg};
    assign sum_sat  = (sum_wide[SUM_W] == sum_wide[SUM_W-1]) ? sum_wide[SUM_W-1:0]
                    : (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX);

    assign err_mag   = err_reg[ERR_W-1] ? -err_reg : err_reg;
    assign diff_calc = {err_reg[ERR_W-1], err_reg} - {prev_error_reg[ERR_W-1], prev_error_reg};

    assign gain_lane[LANE_PROP]  = cfg.gain_prop;
    assign gain_lane[LANE_INTEG] = cfg.gain_integ;
    assign gain_lane[LANE_DERIV] = cfg.gain_deriv;

    assign lane_val[LANE_PROP]  = {{(MAG_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
    assign lane_val[LANE_INTEG] = error_sum_reg;
    assign lane_val[LANE_DERIV] = {{(MAG_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        assign lane_mag[i]  = lane_val[i][MAG_W-1] ? -lane_val[i] : lane_val[i];
        // one 32x24 multiplier per lane, low digit first then high digit
        assign digit_sel[i] = (state_reg == BK_MUL_HI) ? mag_reg[i][MAG_W-1:DIGIT_W]
                                                       : mag_reg[i][DIGIT_W-1:0];
        assign prod[i]      = PART_W'(gain_lane[i]) * PART_W'(digit_sel[i]);
        assign term_calc[i] = PROD_W'(plo_reg[i]) + (PROD_W'(phi_reg[i]) << DIGIT_W);
        assign term_sat[i]  = (term_reg[i] > TERM_LIM) ? TERM_LIM[SAT_W-1:0]
                                                       : term_reg[i][SAT_W-1:0];
        assign sterm_calc[i] = neg_reg[i] ? -{1'b0, term_sat[i]} : {1'b0, term_sat[i]};
    end

    assign total_neg = -({{(ACC_W-TERM_W){sterm_reg[LANE_PROP][TERM_W-1]}},
                          sterm_reg[LANE_PROP]}
                       + {{(ACC_W-TERM_W){sterm_reg[LANE_INTEG][TERM_W-1]}},
                          sterm_reg[LANE_INTEG]}
                       + {{(ACC_W-TERM_W){sterm_reg[LANE_DERIV][TERM_W-1]}},
                          sterm_reg[LANE_DERIV]});

    // Floor to drive units, then clamp
    assign quo         = sum_reg[ACC_W-1:FRAC_W];
    assign lim_q       = {{(QUO_W-LIMIT_W){1'b0}}, cfg.output_limit};
    assign neg_lim_q   = -lim_q;
    assign quo_clamped = (quo > lim_q) ? lim_q : ((quo < neg_lim_q) ? neg_lim_q : quo);

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next        = state_reg;
        target_next       = target_reg;
        prev_error_next   = prev_error_reg;
        error_sum_next    = error_sum_reg;
        last_drive_next   = last_drive_reg;
        stable_count_next = stable_count_reg;
        tick_count_next   = tick_count_reg;
        phase_next        = phase_reg;
        pos_next          = pos_reg;
        err_next          = err_reg;
        diff_next         = diff_reg;
        in_band_next      = in_band_reg;
        mag_next          = mag_reg;
        neg_next          = neg_reg;
        plo_next          = plo_reg;
        phi_next          = phi_reg;
        term_next         = term_reg;
        sterm_next        = sterm_reg;
        sum_next          = sum_reg;
        res_drive_next    = res_drive_reg;
        res_status_next   = res_status_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        drive_next        = drive_reg;
        status_next       = status_reg;
        head_ready        = 1'b0;
        done_valid        = 1'b0;
        done_drive        = '0;
        done_status       = PH_IDLE;

        unique case (state_reg)
            BK_FETCH:
            begin
                if (head_valid)
                begin
                    head_ready = 1'b1;
                    pos_next   = head_item.position;
                    if (head_item.kind == KIND_START)
                    begin
                        target_next       = head_item.target;
                        prev_error_next   = '0;
                        error_sum_next    = '0;
                        last_drive_next   = '0;
                        stable_count_next = '0;
                        tick_count_next   = '0;
                        phase_next        = PH_RUN;
                    end
                    state_next = BK_CHECK;
                end
            end
            BK_CHECK:
            begin
                if (phase_reg != PH_RUN)
                begin
                    done_valid  = 1'b1;
                    done_status = phase_reg;
                end
                else if (tick_count_reg >= cfg.timeout_ticks)
                begin
                    phase_next  = PH_TIMEOUT;
                    done_valid  = 1'b1;
                    done_status = PH_TIMEOUT;
                end
                else
                begin
                    tick_count_next = tick_count_reg + 1'b1;
                    err_next   = {target_reg[POS_W-1], target_reg} - {pos_reg[POS_W-1], pos_reg};
                    state_next = BK_ACCUM;
                end
            end
            BK_ACCUM:
            begin
                if (integrate)
                begin
                    error_sum_next = sum_sat;
                end
                diff_next       = diff_calc;
                prev_error_next = err_reg;
                in_band_next    = err_mag <= {{(ERR_W-BAND_W){1'b0}}, cfg.settle_band};
                state_next      = BK_MAG;
            end
            BK_MAG:
            begin
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    mag_next[i] = lane_mag[i];
                    neg_next[i] = lane_val[i][MAG_W-1];
                end
                state_next = BK_MUL_LO;
            end
            BK_MUL_LO:
            begin
                plo_next   = prod;
                state_next = BK_MUL_HI;
            end
            BK_MUL_HI:
            begin
                phi_next   = prod;
                state_next = BK_COMBINE;
            end
            BK_COMBINE:
            begin
                term_next  = term_calc;
                state_next = BK_SAT;
            end
            BK_SAT:
            begin
                sterm_next = sterm_calc;
                state_next = BK_SUM;
            end
            BK_SUM:
            begin
                sum_next   = total_neg;
                state_next = BK_FINISH;
            end
            BK_FINISH:
            begin
                last_drive_next = quo_clamped[DRIVE_W-1:0];
                done_valid      = 1'b1;
                done_status     = PH_RUN;
                if (in_band_reg)
                begin
                    // hold drive at zero while on target
                    if (stable_count_reg >= cfg.settle_ticks)
                    begin
                        phase_next  = PH_SETTLED;
                        done_status = PH_SETTLED;
                    end
                    else
                    begin
                        stable_count_next = stable_count_reg + 1'b1;
                    end
                end
                else
                begin
                    stable_count_next = '0;
                    done_drive        = quo_clamped[DRIVE_W-1:0];
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    drive_next     = res_drive_reg;
                    status_next    = res_status_reg;
                    state_next     = BK_FETCH;
                end
            end
            default:
            begin
                state_next = BK_FETCH;
            end
        endcase

        // Deliver straight to the output register when it is free, else park
        if (done_valid)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                drive_next     = done_drive;
                status_next    = done_status;
                state_next     = BK_FETCH;
            end
            else
            begin
                res_drive_next  = done_drive;
                res_status_next = done_status;
                state_next      = BK_EMIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_FETCH;
            target_reg       <= '0;
            prev_error_reg   <= '0;
            error_sum_reg    <= '0;
            last_drive_reg   <= '0;
            stable_count_reg <= '0;
            tick_count_reg   <= '0;
            phase_reg        <= PH_IDLE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            target_reg       <= target_next;
            prev_error_reg   <= prev_error_next;
            error_sum_reg    <= error_sum_next;
            last_drive_reg   <= last_drive_next;
            stable_count_reg <= stable_count_next;
            tick_count_reg   <= tick_count_next;
            phase_reg        <= phase_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        err_reg        <= err_next;
        diff_reg       <= diff_next;
        in_band_reg    <= in_band_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        plo_reg        <= plo_next;
        phi_reg        <= phi_next;
        term_reg       <= term_next;
        sterm_reg      <= sterm_next;
        sum_reg        <= sum_next;
        res_drive_reg  <= res_drive_next;
        res_status_reg <= res_status_next;
        drive_reg      <= drive_next;
        status_reg     <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign status    = status_reg;

endmodule
`default_nettype wire
